/* hw/rtl/slcc_pkg.sv */
// Shared types and constants for the source line comment classifier.
// No dependencies; used by source_line_comment_classifier_unit.
`default_nettype none

package slcc_pkg;

    // Lexer modes, one-hot
    typedef enum logic [4:0] {
        LX_CODE          = 5'b00001,
        LX_STRING        = 5'b00010,
        LX_CHAR          = 5'b00100,
        LX_LINE_COMMENT  = 5'b01000,
        LX_BLOCK_COMMENT = 5'b10000
    } lexer_mode_t;

    // Item kinds on the input channel
    localparam logic MODE_CHAR = 1'b0;
    localparam logic MODE_EOL  = 1'b1;

    // Delimiter bytes
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;

    typedef struct packed {
        logic       mode;
        logic [7:0] character;
    } src_word_t;

    typedef struct packed {
        logic line_blank;
        logic line_has_code;
        logic line_has_comment;
    } res_word_t;

    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) ||
                   (c == 8'h0B) || (c == 8'h0C) || (c == 8'h0D);
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/source_line_comment_classifier_unit.sv */
// Top level of the source line comment classifier.
// Depends on slcc_pkg for word types, lexer modes and delimiter constants.
//
// Usage:
//   src channel (src_valid / src_stall / src_word) carries one word per source
//   byte (mode = character) or one end-of-line word (mode = end of line).
//   res channel (res_valid / res_stall / res_word) carries one word per end of
//   line: blank, has code, has comment flags for the line just closed.
//   Character words produce no result.
// Throughput: one source word per cycle while src_stall is low. Each word is
//   captured in an input register, and the lexer state is updated from there.
// Result path: the result of an end-of-line word is computed from the input
//   register and registered in the output register (or the skid register).
// Stall: results queue in an output register plus one skid register, so the
//   source keeps flowing while one result waits. src_stall rises only when the
//   skid register is full and a word waits in the input register.
// Reset (rst_n low, asynchronous): lexer in code mode, all flags cleared,
//   no words held on either side.
`default_nettype none

module source_line_comment_classifier_unit (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 src_valid,
    output logic                src_stall,
    input  slcc_pkg::src_word_t src_word,
    output logic                res_valid,
    input  wire                 res_stall,
    output slcc_pkg::res_word_t res_word
);

    // Input stage
    logic                in_valid_reg;
    slcc_pkg::src_word_t in_word_reg;

    // Lexer state
    slcc_pkg::lexer_mode_t lex_mode_reg, lex_mode_next;
    logic escaped_reg, escaped_next;
    logic pending_reg, pending_next;
    logic nonblank_reg, nonblank_next;
    logic code_reg, code_next;
    logic comment_reg, comment_next;

    // Output register and skid
    logic                out_valid_reg;
    slcc_pkg::res_word_t out_word_reg;
    logic                skid_valid_reg;
    slcc_pkg::res_word_t skid_word_reg;

    logic                src_take;
    logic                fire;
    logic                produce;
    logic                out_pop;
    slcc_pkg::res_word_t result;

    assign src_stall = in_valid_reg & skid_valid_reg;
    assign src_take  = src_valid & ~src_stall;
    assign fire      = in_valid_reg & ~skid_valid_reg;
    assign produce   = fire & (in_word_reg.mode == slcc_pkg::MODE_EOL);
    assign out_pop   = out_valid_reg & ~res_stall;

    assign res_valid = out_valid_reg;
    assign res_word  = out_word_reg;

    // Capture source words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (src_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_take)
        begin
            in_word_reg <= src_word;
        end
    end

    // Lexer next state
    always_comb
    begin
        logic [7:0] c;
        logic       done;
        logic       esc_upd;
        logic       pend_code;

        c         = in_word_reg.character;
        done      = 1'b0;
        esc_upd   = (c == slcc_pkg::CH_BACKSLASH) ? ~escaped_reg : 1'b0;
        pend_code = pending_reg & (lex_mode_reg == slcc_pkg::LX_CODE);

        lex_mode_next = lex_mode_reg;
        escaped_next  = escaped_reg;
        pending_next  = pending_reg;
        nonblank_next = nonblank_reg;
        code_next     = code_reg;
        comment_next  = comment_reg;

        result.line_blank       = ~nonblank_reg;
        result.line_has_code    = code_reg | pend_code;
        result.line_has_comment = comment_reg;

        if (in_word_reg.mode == slcc_pkg::MODE_CHAR)
        begin
            // Resolve a held slash or star against this byte
            if (pending_reg)
            begin
                pending_next = 1'b0;
                if (lex_mode_reg == slcc_pkg::LX_CODE)
                begin
                    if (c == slcc_pkg::CH_SLASH || c == slcc_pkg::CH_STAR)
                    begin
                        lex_mode_next = (c == slcc_pkg::CH_SLASH) ?
                            slcc_pkg::LX_LINE_COMMENT : slcc_pkg::LX_BLOCK_COMMENT;
                        comment_next  = 1'b1;
                        escaped_next  = 1'b0;
                        done          = 1'b1;
                    end
                    else
                    begin
                        code_next = 1'b1;
                    end
                end
                else if (lex_mode_reg == slcc_pkg::LX_BLOCK_COMMENT)
                begin
                    if (c == slcc_pkg::CH_SLASH)
                    begin
                        lex_mode_next = slcc_pkg::LX_CODE;
                        escaped_next  = 1'b0;
                        done          = 1'b1;
                    end
                end
            end

            // Ordinary byte handling; whitespace leaves everything alone
            if (!done && !slcc_pkg::is_space(c))
            begin
                nonblank_next = 1'b1;
                escaped_next  = esc_upd;
                unique case (lex_mode_reg)
                    slcc_pkg::LX_CODE:
                    begin
                        if (!escaped_reg && c == slcc_pkg::CH_SLASH)
                        begin
                            pending_next = 1'b1;
                            escaped_next = 1'b0;
                        end
                        else
                        begin
                            code_next = 1'b1;
                            if (c == slcc_pkg::CH_SQUOTE)
                            begin
                                lex_mode_next = slcc_pkg::LX_CHAR;
                            end
                            else if (!escaped_reg && c == slcc_pkg::CH_DQUOTE)
                            begin
                                lex_mode_next = slcc_pkg::LX_STRING;
                            end
                        end
                    end
                    slcc_pkg::LX_STRING:
                    begin
                        code_next = 1'b1;
                        if (c == slcc_pkg::CH_DQUOTE && !escaped_reg)
                        begin
                            lex_mode_next = slcc_pkg::LX_CODE;
                        end
                    end
                    slcc_pkg::LX_CHAR:
                    begin
                        code_next = 1'b1;
                        if (c == slcc_pkg::CH_SQUOTE && !escaped_reg)
                        begin
                            lex_mode_next = slcc_pkg::LX_CODE;
                        end
                    end
                    slcc_pkg::LX_LINE_COMMENT:
                    begin
                        comment_next = 1'b1;
                    end
                    slcc_pkg::LX_BLOCK_COMMENT:
                    begin
                        comment_next = 1'b1;
                        if (c == slcc_pkg::CH_STAR)
                        begin
                            pending_next = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        else
        begin
            // End of line: an escaped line end keeps the mode, as does an open block comment
            if (!(escaped_reg && !pend_code) &&
                lex_mode_reg != slcc_pkg::LX_BLOCK_COMMENT)
            begin
                lex_mode_next = slcc_pkg::LX_CODE;
            end
            escaped_next  = 1'b0;
            pending_next  = 1'b0;
            nonblank_next = 1'b0;
            code_next     = 1'b0;
            comment_next  = (lex_mode_next == slcc_pkg::LX_LINE_COMMENT) ||
                            (lex_mode_next == slcc_pkg::LX_BLOCK_COMMENT);
        end
    end

    // Advance lexer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lex_mode_reg <= slcc_pkg::LX_CODE;
            escaped_reg  <= 1'b0;
            pending_reg  <= 1'b0;
            nonblank_reg <= 1'b0;
            code_reg     <= 1'b0;
            comment_reg  <= 1'b0;
        end
        else if (fire)
        begin
            lex_mode_reg <= lex_mode_next;
            escaped_reg  <= escaped_next;
            pending_reg  <= pending_next;
            nonblank_reg <= nonblank_next;
            code_reg     <= code_next;
            comment_reg  <= comment_next;
        end
    end

    // Output register and skid control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (out_pop)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (produce)
            begin
                out_valid_reg <= 1'b1;
                if (out_valid_reg && !out_pop)
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
            else if (out_pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payloads
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_pop)
            begin
                out_word_reg <= skid_word_reg;
            end
        end
        else if (produce)
        begin
            if (!out_valid_reg || out_pop)
            begin
                out_word_reg <= result;
            end
            else
            begin
                skid_word_reg <= result;
            end
        end
    end

    // Checks
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a word while output register is empty");

    a_pending_mode: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg |-> (lex_mode_reg == slcc_pkg::LX_CODE ||
                         lex_mode_reg == slcc_pkg::LX_BLOCK_COMMENT))
        else $error("pending delimiter outside code or block comment");

    a_comment_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (lex_mode_reg == slcc_pkg::LX_LINE_COMMENT ||
         lex_mode_reg == slcc_pkg::LX_BLOCK_COMMENT) |-> comment_reg)
        else $error("comment mode without comment flag");

endmodule

`default_nettype wire
